FILE: sv/g6d_pkg.sv
// Shared types and constants of the graph6 edge decoder.
package g6d_pkg;

  localparam int NODE_W        = 36;
  localparam int IDX_OUT_W     = 12;
  localparam int CHAR_BIAS     = 63;
  localparam int CHAR_TOP      = 126;
  localparam int SMALL_MAX     = 62;
  localparam int BITS_PER_CHAR = 6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_LENGTH   = 2'd2;
  localparam logic [1:0] ST_TOO_MANY = 2'd3;

  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_char;
  } in_t;

  typedef struct packed {
    logic                 kind;
    logic [IDX_OUT_W-1:0] node_a;
    logic [IDX_OUT_W-1:0] node_b;
    logic [IDX_OUT_W-1:0] node_total;
    logic [1:0]           status;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic                 fin;
    logic [2:0]           nvalid;
    logic [5:0]           bits;
    logic [IDX_OUT_W-1:0] total;
    logic [1:0]           status;
  } cmd_t;

endpackage

FILE: sv/g6d_front.sv
// Character intake: header decode, pair budget, error tracking, command issue.
module g6d_front #(
  parameter int NODE_BITS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  g6d_pkg::in_t  in_item,
  input  logic          q_full,
  output logic          cmd_push,
  output g6d_pkg::cmd_t cmd
);

  localparam int PW = 2 * NODE_BITS + 1;
  localparam int RW = 2 * NODE_BITS;
  localparam logic [g6d_pkg::NODE_W:0] CAP = (g6d_pkg::NODE_W + 1)'(1) << NODE_BITS;

  typedef enum logic [1:0] {FORM_NONE, FORM_SHORT, FORM_FOUR, FORM_EIGHT} form_t;

  form_t                      form_r, form_nxt;
  logic [3:0]                 cnt_r, cnt_nxt;
  logic [g6d_pkg::NODE_W-1:0] node_r, node_nxt;
  logic                       hdr_done_r, hdr_done_nxt;
  logic                       pdone_r, pdone_nxt;
  logic [1:0]                 err_r, err_nxt;
  logic [RW-1:0]              rem_r, rem_nxt;
  logic                       busy_r, busy_nxt;
  logic [PW-1:0]              acc_r, acc_nxt;
  logic [PW-1:0]              mcand_r, mcand_nxt;
  logic [NODE_BITS-1:0]       mplier_r, mplier_nxt;

  logic       accept;
  logic       bad;
  logic       hdr_fin;
  logic [5:0] v;
  logic [2:0] nv;
  logic [PW-1:0] acc_sum;

  assign full   = q_full || busy_r;
  assign accept = push && !full;

  always_comb begin
    form_nxt     = form_r;
    cnt_nxt      = cnt_r;
    node_nxt     = node_r;
    hdr_done_nxt = hdr_done_r;
    pdone_nxt    = pdone_r;
    err_nxt      = err_r;
    rem_nxt      = rem_r;
    busy_nxt     = busy_r;
    acc_nxt      = acc_r;
    mcand_nxt    = mcand_r;
    mplier_nxt   = mplier_r;
    cmd_push     = 1'b0;
    cmd          = '0;
    hdr_fin      = 1'b0;
    nv           = 3'd0;
    acc_sum      = mplier_r[0] ? acc_r + mcand_r : acc_r;
    v            = 6'(in_item.text_byte - 8'(g6d_pkg::CHAR_BIAS));
    bad          = (in_item.text_byte < 8'(g6d_pkg::CHAR_BIAS)) ||
                   (in_item.text_byte > 8'(g6d_pkg::CHAR_TOP));

    // advance pair-count multiply
    if (busy_r) begin
      acc_nxt    = acc_sum;
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      if (mplier_r[NODE_BITS-1:1] == '0) begin
        busy_nxt = 1'b0;
        rem_nxt  = RW'(acc_sum >> 1);
      end
    end

    if (accept) begin
      if (err_r == g6d_pkg::ST_OK) begin
        if (bad) begin
          err_nxt = g6d_pkg::ST_BAD_CHAR;
        end else if (!hdr_done_r) begin
          unique case (form_r)
            FORM_NONE: begin
              cnt_nxt = 4'd1;
              if (v <= 6'(g6d_pkg::SMALL_MAX)) begin
                node_nxt = g6d_pkg::NODE_W'(v);
                form_nxt = FORM_SHORT;
                hdr_fin  = 1'b1;
              end else begin
                form_nxt = FORM_FOUR;
              end
            end
            FORM_FOUR: begin
              if (cnt_r == 4'd1 && v > 6'(g6d_pkg::SMALL_MAX)) begin
                form_nxt = FORM_EIGHT;
                cnt_nxt  = 4'd2;
              end else begin
                node_nxt = {node_r[g6d_pkg::NODE_W-7:0], v};
                cnt_nxt  = cnt_r + 4'd1;
                hdr_fin  = (cnt_nxt == 4'd4);
              end
            end
            FORM_EIGHT: begin
              node_nxt = {node_r[g6d_pkg::NODE_W-7:0], v};
              cnt_nxt  = cnt_r + 4'd1;
              hdr_fin  = (cnt_nxt == 4'd8);
            end
            default: begin
              node_nxt = node_r;
            end
          endcase
          if (hdr_fin) begin
            hdr_done_nxt = 1'b1;
            pdone_nxt    = (node_nxt < g6d_pkg::NODE_W'(2));
            rem_nxt      = '0;
            if ({1'b0, node_nxt} > CAP) begin
              err_nxt = g6d_pkg::ST_TOO_MANY;
            end else if (!pdone_nxt && !in_item.final_char) begin
              busy_nxt   = 1'b1;
              acc_nxt    = '0;
              mcand_nxt  = PW'(node_nxt);
              mplier_nxt = NODE_BITS'(node_nxt - g6d_pkg::NODE_W'(1));
            end
          end
        end else if (pdone_r) begin
          err_nxt = g6d_pkg::ST_LENGTH;
        end else begin
          nv         = (rem_r >= RW'(g6d_pkg::BITS_PER_CHAR)) ?
                       3'(g6d_pkg::BITS_PER_CHAR) : 3'(rem_r);
          rem_nxt    = rem_r - RW'(nv);
          pdone_nxt  = (rem_nxt == '0);
          cmd.nvalid = nv;
          cmd.bits   = v & ~(6'h3F >> nv);
          cmd_push   = 1'b1;
        end
      end

      if (in_item.final_char) begin
        cmd.fin   = 1'b1;
        cmd.total = hdr_done_nxt ? g6d_pkg::IDX_OUT_W'(node_nxt) : '0;
        if (err_nxt != g6d_pkg::ST_OK) begin
          cmd.status = err_nxt;
        end else if (!hdr_done_nxt || !pdone_nxt) begin
          cmd.status = g6d_pkg::ST_LENGTH;
        end else begin
          cmd.status = g6d_pkg::ST_OK;
        end
        cmd_push     = 1'b1;
        form_nxt     = FORM_NONE;
        cnt_nxt      = 4'd0;
        node_nxt     = '0;
        hdr_done_nxt = 1'b0;
        pdone_nxt    = 1'b0;
        err_nxt      = g6d_pkg::ST_OK;
        rem_nxt      = '0;
        busy_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      form_r     <= FORM_NONE;
      cnt_r      <= 4'd0;
      node_r     <= '0;
      hdr_done_r <= 1'b0;
      pdone_r    <= 1'b0;
      err_r      <= g6d_pkg::ST_OK;
      rem_r      <= '0;
      busy_r     <= 1'b0;
    end else begin
      form_r     <= form_nxt;
      cnt_r      <= cnt_nxt;
      node_r     <= node_nxt;
      hdr_done_r <= hdr_done_nxt;
      pdone_r    <= pdone_nxt;
      err_r      <= err_nxt;
      rem_r      <= rem_nxt;
      busy_r     <= busy_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

endmodule

FILE: sv/g6d_cmd_fifo.sv
// Two-entry command queue between intake and edge walker.
module g6d_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  g6d_pkg::cmd_t wdata,
  output logic          full,
  input  logic          rd_en,
  output g6d_pkg::cmd_t rdata,
  output logic          empty
);

  g6d_pkg::cmd_t mem_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_wr;
  logic          do_rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_comb begin
    wp_nxt  = do_wr ? ~wp_r : wp_r;
    rp_nxt  = do_rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: sv/g6d_back.sv
// Edge walker: walks upper triangle one bit per cycle unless stalled, drives out_r.
module g6d_back #(
  parameter int NODE_BITS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  g6d_pkg::cmd_t cmd,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output g6d_pkg::out_t out_item
);

  logic [2:0]           step_r, step_nxt;
  logic [NODE_BITS-1:0] row_r, row_nxt;
  logic [NODE_BITS-1:0] col_r, col_nxt;
  logic                 ovalid_r, ovalid_nxt;
  g6d_pkg::out_t        out_r, out_nxt;

  logic       out_free;
  logic       data_phase;
  logic [5:0] sh;
  logic       emit;
  logic       go;

  assign out_free   = !ovalid_r || pop;
  assign data_phase = (step_r < cmd.nvalid);
  assign sh         = cmd.bits << step_r;
  assign empty      = !ovalid_r;
  assign out_item   = out_r;

  always_comb begin
    step_nxt   = step_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    ovalid_nxt = ovalid_r && !pop;
    out_nxt    = out_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    go         = 1'b0;

    if (!q_empty) begin
      if (data_phase) begin
        emit = sh[5];
        go   = !sh[5] || out_free;
        if (emit) begin
          out_nxt.kind       = g6d_pkg::KIND_EDGE;
          out_nxt.node_a     = g6d_pkg::IDX_OUT_W'(row_r);
          out_nxt.node_b     = g6d_pkg::IDX_OUT_W'(col_r);
          out_nxt.node_total = '0;
          out_nxt.status     = g6d_pkg::ST_OK;
          out_nxt.last       = !cmd.fin && (sh[4:0] == 5'd0);
        end
        if (go) begin
          row_nxt = row_r + NODE_BITS'(1);
          if (row_nxt == col_r) begin
            row_nxt = '0;
            col_nxt = col_r + NODE_BITS'(1);
          end
          if ((3'(step_r + 3'd1) == cmd.nvalid) && !cmd.fin) begin
            step_nxt = 3'd0;
            q_pop    = 1'b1;
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end else begin
        emit               = 1'b1;
        go                 = out_free;
        out_nxt.kind       = g6d_pkg::KIND_SUMMARY;
        out_nxt.node_a     = '0;
        out_nxt.node_b     = '0;
        out_nxt.node_total = cmd.total;
        out_nxt.status     = cmd.status;
        out_nxt.last       = 1'b1;
        if (go) begin
          step_nxt = 3'd0;
          row_nxt  = '0;
          col_nxt  = NODE_BITS'(1);
          q_pop    = 1'b1;
        end
      end
      if (emit && go) begin
        ovalid_nxt = 1'b1;
      end else begin
        out_nxt = out_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= 3'd0;
      row_r    <= '0;
      col_r    <= NODE_BITS'(1);
      ovalid_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      ovalid_r <= ovalid_nxt;
    end
    out_r <= out_nxt;
  end

endmodule

FILE: sv/graph6_edge_decoder_core.sv
// Top level of the graph6 edge decoder.
//
//   Channel  | Ports                     | Beat
//   ---------+---------------------------+-------------------------------------
//   input    | push, full, in_item       | one graph6 character, end-of-string
//   result   | empty, pop, out_item      | one edge pair or one string summary
//
// A character is taken when push is high and full is low; the walker steps
// one pair bit at a time through each data character, then emits a summary.
// Once a header of two or more nodes completes within the node limit and the
// string goes on, a shift-add multiply sizes the triangle and holds full high
// while it runs. Reset is synchronous and clears all string state. A two-entry
// command queue lets intake run ahead of the walker; pop low holds the result
// register and stalls the walker, and full rises once the command queue fills.
module graph6_edge_decoder_core #(
  parameter int NODE_BITS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  g6d_pkg::in_t  in_item,
  output logic          empty,
  input  logic          pop,
  output g6d_pkg::out_t out_item
);

  logic          q_full;
  logic          q_empty;
  logic          cmd_push;
  logic          q_pop;
  g6d_pkg::cmd_t cmd_in;
  g6d_pkg::cmd_t cmd_head;

  g6d_front #(.NODE_BITS(NODE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .q_full   (q_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  g6d_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cmd_push),
    .wdata (cmd_in),
    .full  (q_full),
    .rd_en (q_pop),
    .rdata (cmd_head),
    .empty (q_empty)
  );

  g6d_back #(.NODE_BITS(NODE_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .cmd      (cmd_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

FILE: sv/g6d_checker.sv
// Port-level checks of the graph6 edge decoder, bound to the top level.
module g6d_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input g6d_pkg::out_t out_item
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("block not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed");

  a_summary_form: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.kind == g6d_pkg::KIND_SUMMARY |->
      out_item.last && out_item.node_a == '0 && out_item.node_b == '0)
    else $error("malformed summary");

  a_edge_form: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.kind == g6d_pkg::KIND_EDGE |->
      out_item.node_total == '0 && out_item.status == g6d_pkg::ST_OK)
    else $error("malformed edge");

endmodule

bind graph6_edge_decoder_core g6d_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the graph6 edge decoder core: directed and random strings, edges and summaries.
module tb;

  localparam int NODE_LIMIT_BITS = 12;
  localparam int ITEM_TARGET     = 350;
  localparam int MAX_WAIT        = 11;
  localparam int ERR_SHOWN       = 10;

  localparam logic [1:0] FORM_NONE  = 2'd0;
  localparam logic [1:0] FORM_SHORT = 2'd1;
  localparam logic [1:0] FORM_FOUR  = 2'd2;
  localparam logic [1:0] FORM_EIGHT = 2'd3;

  typedef enum int {FLAW_NONE, FLAW_BAD, FLAW_SHORT, FLAW_EXTRA, FLAW_NOISE} flaw_t;

  typedef struct {
    g6d_pkg::in_t beat;
    int           gap;
    bit           drain;
  } send_t;

  logic          clk     = 1'b0;
  logic          rst_n   = 1'b0;
  logic          push    = 1'b0;
  logic          pop     = 1'b0;
  g6d_pkg::in_t  in_item = '0;
  logic          full;
  logic          empty;
  g6d_pkg::out_t out_item;

  graph6_edge_decoder_core #(.NODE_BITS(NODE_LIMIT_BITS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  logic [3:0]  hdr_cnt;
  logic [1:0]  hdr_form;
  logic [35:0] node_cnt;
  int unsigned row_idx;
  int unsigned col_idx;
  bit          pairs_done;
  logic [1:0]  str_err;

  g6d_pkg::out_t decoded_q[$];
  send_t         char_q[$];
  logic [7:0]    str_q[$];

  send_t cur;
  bit    cur_loaded;
  bit    char_taken;
  bit    beat_taken;
  bit    in_burst;
  bit    out_burst;
  int    in_gap;
  int    pop_gap;

  int fails;
  int n_queued;
  int n_strings;
  int n_chars;
  int n_edges;
  int n_sums;
  int st_seen[4];

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit header_done();
    return hdr_form == FORM_SHORT || (hdr_form == FORM_FOUR && hdr_cnt == 4'd4) ||
           (hdr_form == FORM_EIGHT && hdr_cnt == 4'd8);
  endfunction

  task automatic reset_decoder();
    hdr_cnt    = '0;
    hdr_form   = FORM_NONE;
    node_cnt   = '0;
    row_idx    = 0;
    col_idx    = 1;
    pairs_done = 1'b0;
    str_err    = g6d_pkg::ST_OK;
  endtask

  task automatic decode_char(input g6d_pkg::in_t c);
    g6d_pkg::out_t res_q[$];
    g6d_pkg::out_t r;
    logic [5:0]    v;
    logic [1:0]    st;
    bit            hdr;
    if (str_err == g6d_pkg::ST_OK) begin
      if (c.text_byte < g6d_pkg::CHAR_BIAS || c.text_byte > g6d_pkg::CHAR_TOP) begin
        str_err = g6d_pkg::ST_BAD_CHAR;
      end else begin
        v = 6'(c.text_byte - g6d_pkg::CHAR_BIAS);
        if (!header_done()) begin
          if (hdr_form == FORM_NONE) begin
            hdr_cnt = 4'd1;
            if (v <= g6d_pkg::SMALL_MAX) begin
              node_cnt = 36'(v);
              hdr_form = FORM_SHORT;
            end else begin
              hdr_form = FORM_FOUR;
            end
          end else if (hdr_form == FORM_FOUR && hdr_cnt == 4'd1 &&
                       v > g6d_pkg::SMALL_MAX) begin
            hdr_form = FORM_EIGHT;
            hdr_cnt  = 4'd2;
          end else begin
            node_cnt = {node_cnt[29:0], v};
            hdr_cnt  = hdr_cnt + 4'd1;
          end
          if (header_done()) begin
            if (node_cnt > (36'd1 << NODE_LIMIT_BITS)) str_err = g6d_pkg::ST_TOO_MANY;
            row_idx    = 0;
            col_idx    = 1;
            pairs_done = node_cnt < 36'd2;
          end
        end else if (pairs_done) begin
          str_err = g6d_pkg::ST_LENGTH;
        end else begin
          for (int k = g6d_pkg::BITS_PER_CHAR - 1; k >= 0 && !pairs_done; k--) begin
            if (v[k]) begin
              r        = '0;
              r.kind   = g6d_pkg::KIND_EDGE;
              r.node_a = row_idx[g6d_pkg::IDX_OUT_W-1:0];
              r.node_b = col_idx[g6d_pkg::IDX_OUT_W-1:0];
              res_q    = {res_q, r};
            end
            row_idx++;
            if (row_idx == col_idx) begin
              row_idx = 0;
              col_idx++;
              if (col_idx >= node_cnt) pairs_done = 1'b1;
            end
          end
        end
      end
    end
    if (c.final_char) begin
      hdr = header_done();
      st  = str_err;
      if (st == g6d_pkg::ST_OK && (!hdr || !pairs_done)) st = g6d_pkg::ST_LENGTH;
      r            = '0;
      r.kind       = g6d_pkg::KIND_SUMMARY;
      r.node_total = hdr ? node_cnt[g6d_pkg::IDX_OUT_W-1:0] : '0;
      r.status     = st;
      res_q        = {res_q, r};
      reset_decoder();
    end
    if (res_q.size() > 0) res_q[$].last = 1'b1;
    decoded_q = {decoded_q, res_q};
  endtask

  task automatic queue_char(input logic [7:0] b, input bit fin, input bit drain);
    send_t s;
    if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
    s.beat.text_byte  = b;
    s.beat.final_char = fin;
    s.gap             = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
    s.drain           = drain;
    char_q            = {char_q, s};
  endtask

  task automatic flush_string(input bit drain);
    foreach (str_q[i]) queue_char(str_q[i], i == str_q.size() - 1, drain && i == 0);
    n_queued += str_q.size();
    n_strings++;
    str_q.delete();
  endtask

  task automatic make_string(input logic [35:0] n, input logic [1:0] form, input flaw_t flaw);
    int pairs;
    int nchars;
    int idx;
    case (form)
      FORM_SHORT: str_q = {str_q, 8'(g6d_pkg::CHAR_BIAS + n)};
      FORM_FOUR: begin
        str_q = {str_q, 8'(g6d_pkg::CHAR_TOP)};
        for (int i = 2; i >= 0; i--) begin
          str_q = {str_q, 8'(g6d_pkg::CHAR_BIAS + ((n >> (6 * i)) & 36'h3F))};
        end
      end
      default: begin
        str_q = {str_q, 8'(g6d_pkg::CHAR_TOP)};
        str_q = {str_q, 8'(g6d_pkg::CHAR_TOP)};
        for (int i = 5; i >= 0; i--) begin
          str_q = {str_q, 8'(g6d_pkg::CHAR_BIAS + ((n >> (6 * i)) & 36'h3F))};
        end
      end
    endcase
    if (n <= 36'd40) begin
      pairs  = (n < 36'd2) ? 0 : int'(n) * (int'(n) - 1) / 2;
      nchars = (pairs + g6d_pkg::BITS_PER_CHAR - 1) / g6d_pkg::BITS_PER_CHAR;
    end else begin
      nchars = $urandom_range(0, 3);
    end
    repeat (nchars) str_q = {str_q, 8'(g6d_pkg::CHAR_BIAS + $urandom_range(0, 63))};
    case (flaw)
      FLAW_BAD: begin
        idx = $urandom_range(0, str_q.size() - 1);
        str_q[idx] = $urandom_range(0, 1) ?
                     8'($urandom_range(0, g6d_pkg::CHAR_BIAS - 1)) :
                     8'($urandom_range(g6d_pkg::CHAR_TOP + 1, 255));
      end
      FLAW_SHORT: begin
        if (str_q.size() > 1) repeat ($urandom_range(1, str_q.size() - 1)) void'(str_q.pop_back());
      end
      FLAW_EXTRA: begin
        repeat ($urandom_range(1, 2)) begin
          str_q = {str_q, 8'(g6d_pkg::CHAR_BIAS + $urandom_range(0, 63))};
        end
      end
      FLAW_NOISE: begin
        str_q.delete();
        repeat ($urandom_range(1, 5)) str_q = {str_q, 8'($urandom)};
      end
      default: ;
    endcase
    flush_string($urandom_range(0, 9) == 0);
  endtask

  always @(posedge clk) begin : monitor
    g6d_pkg::out_t want;
    if (rst_n) begin
      if (push && !full) begin
        decode_char(in_item);
        n_chars++;
        char_taken = 1'b1;
      end
      if (pop && !empty) begin
        beat_taken = 1'b1;
        if (decoded_q.size() == 0) begin
          fails++;
          if (fails <= ERR_SHOWN)
            $display("unexpected beat: kind=%0d a=%0d b=%0d total=%0d status=%0d last=%0d",
                     out_item.kind, out_item.node_a, out_item.node_b, out_item.node_total,
                     out_item.status, out_item.last);
        end else begin
          want = decoded_q.pop_front();
          if (out_item.kind !== want.kind || out_item.node_a !== want.node_a ||
              out_item.node_b !== want.node_b || out_item.node_total !== want.node_total ||
              out_item.status !== want.status || out_item.last !== want.last) begin
            fails++;
            if (fails <= ERR_SHOWN) begin
              $display("bad beat: exp kind=%0d a=%0d b=%0d total=%0d status=%0d last=%0d",
                       want.kind, want.node_a, want.node_b, want.node_total, want.status,
                       want.last);
              $display("          got kind=%0d a=%0d b=%0d total=%0d status=%0d last=%0d",
                       out_item.kind, out_item.node_a, out_item.node_b, out_item.node_total,
                       out_item.status, out_item.last);
            end
          end
          if (want.kind == g6d_pkg::KIND_SUMMARY) begin
            n_sums++;
            st_seen[want.status]++;
          end else begin
            n_edges++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin : drive_in
    bit nxt;
    nxt = push;
    if (rst_n) begin
      if (char_taken) begin
        char_taken = 1'b0;
        cur_loaded = 1'b0;
        nxt        = 1'b0;
      end
      if (!cur_loaded && char_q.size() > 0) begin
        cur        = char_q.pop_front();
        cur_loaded = 1'b1;
        in_gap     = cur.gap;
      end
      if (cur_loaded && !nxt) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (!cur.drain || decoded_q.size() == 0) begin
          nxt = 1'b1;
          in_item <= cur.beat;
        end
      end
    end
    push <= nxt;
  end

  always @(negedge clk) begin : drive_out
    if (beat_taken) begin
      beat_taken = 1'b0;
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      pop_gap = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else begin
      pop <= rst_n;
    end
  end

  initial begin
    int          pick;
    logic [35:0] n;
    logic [1:0]  form;
    flaw_t       flaw;
    reset_decoder();

    str_q = '{8'd63};                        flush_string(1'b0);
    str_q = '{8'd65, 8'd95};                 flush_string(1'b0);
    str_q = '{8'd67, 8'd126};                flush_string(1'b0);
    str_q = '{8'd0};                         flush_string(1'b0);
    str_q = '{8'd65, 8'd255};                flush_string(1'b0);
    str_q = '{8'd65, 8'd95, 8'd95};          flush_string(1'b0);
    str_q = '{8'd126, 8'd63};                flush_string(1'b0);
    str_q = '{8'd126, 8'd63, 8'd63, 8'd66, 8'd126};
    flush_string(1'b1);
    str_q = '{8'd126, 8'd126, 8'd63, 8'd63, 8'd63, 8'd64, 8'd63, 8'd64};
    flush_string(1'b0);

    while (n_queued < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        form = FORM_SHORT;
        n    = $urandom_range(0, 14);
      end else if (pick < 77) begin
        form = FORM_FOUR;
        n    = $urandom_range(0, 24);
      end else if (pick < 83) begin
        form = FORM_EIGHT;
        n    = $urandom_range(0, 10);
      end else if (pick < 90) begin
        form = FORM_FOUR;
        n    = $urandom_range(4097, 262143);
      end else if (pick < 95) begin
        form = FORM_EIGHT;
        n    = {4'($urandom), 32'($urandom)};
      end else begin
        form = FORM_FOUR;
        n    = 36'd4096;
      end
      pick = $urandom_range(0, 99);
      if (pick < 68)      flaw = FLAW_NONE;
      else if (pick < 78) flaw = FLAW_BAD;
      else if (pick < 88) flaw = FLAW_SHORT;
      else if (pick < 94) flaw = FLAW_EXTRA;
      else                flaw = FLAW_NOISE;
      make_string(n, form, flaw);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_q.size() > 0 || cur_loaded || decoded_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d strings, %0d characters; checked %0d edges and %0d summaries",
             n_strings, n_chars, n_edges, n_sums);
    $display("summary status mix: ok %0d, bad char %0d, length %0d, too many %0d",
             st_seen[g6d_pkg::ST_OK], st_seen[g6d_pkg::ST_BAD_CHAR],
             st_seen[g6d_pkg::ST_LENGTH], st_seen[g6d_pkg::ST_TOO_MANY]);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
sv/g6d_pkg.sv
sv/g6d_front.sv
sv/g6d_cmd_fifo.sv
sv/g6d_back.sv
sv/graph6_edge_decoder_core.sv
sv/g6d_checker.sv
tb/sv/tb.sv
